[rtl/htsed_pkg.sv]
// ----------------------------------------------------------------------------
// htsed_pkg
// Shared types, character codes and entity tables for the HTML tag strip /
// entity decode block.
// ----------------------------------------------------------------------------
package htsed_pkg;

  localparam int WINDOW_BYTES_DEF = 6;
  localparam int SEQ_NUM          = 5;
  localparam int SEQ_MAX          = 6;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic keep;
    logic step_push;
    logic flush_push;
    logic can_push;
  } dp_sts_t;

  // Entity k, character j (first character is j = 0).
  function automatic logic [7:0] seq_char(input logic [2:0] k, input logic [2:0] j);
    logic [47:0] row;
    logic [2:0]  ofs;
    case (k)
      3'd0:    row = {"&", "l", "t", ";", 8'h00, 8'h00};
      3'd1:    row = {"&", "g", "t", ";", 8'h00, 8'h00};
      3'd2:    row = {"&", "a", "m", "p", ";", 8'h00};
      3'd3:    row = {"&", "#", "3", "9", ";", "s"};
      3'd4:    row = {"&", "n", "b", "s", "p", ";"};
      default: row = '0;
    endcase
    ofs = 3'(SEQ_MAX - 1) - j;
    if (j > 3'(SEQ_MAX - 1)) begin
      return 8'h00;
    end
    return row[{ofs, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] seq_len(input logic [2:0] k);
    case (k)
      3'd0:    return 3'd4;
      3'd1:    return 3'd4;
      3'd2:    return 3'd5;
      3'd3:    return 3'd6;
      3'd4:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  // Replacement byte; zero means the sequence is dropped.
  function automatic logic [7:0] seq_repl(input logic [2:0] k);
    case (k)
      3'd0:    return CH_LT;
      3'd1:    return CH_GT;
      3'd2:    return CH_AMP;
      default: return 8'h00;
    endcase
  endfunction

endpackage

[rtl/htsed_ctrl.sv]
// ----------------------------------------------------------------------------
// htsed_ctrl
// Sequencer: loads a request into the window, steps the scan one byte per
// cycle unless a push waits on the output, then flushes the held result.
// ----------------------------------------------------------------------------
module htsed_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  htsed_pkg::dp_sts_t sts,
  output htsed_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t state_r;
  logic   stall_r;

  assign in_stall = stall_r | ~rst_n;

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid & ~in_stall;
      end
      ST_SCAN: begin
        if (!(sts.empty || sts.keep)) begin
          cmd.step = ~sts.step_push | sts.can_push;
        end
      end
      ST_FLUSH: begin
        cmd.flush = ~sts.flush_push | sts.can_push;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stall_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.load) begin
            state_r <= ST_SCAN;
            stall_r <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts.empty || sts.keep) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (cmd.flush) begin
            state_r <= ST_IDLE;
            stall_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/htsed_dp.sv]
// ----------------------------------------------------------------------------
// htsed_dp
// Datapath: byte window with the unconsumed bytes at its head, entity
// matcher, tag/newline flags, one held result and the output register.
// ----------------------------------------------------------------------------
module htsed_dp #(
  parameter int WINDOW_BYTES = htsed_pkg::WINDOW_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  htsed_pkg::in_item_t  in_data,
  input  htsed_pkg::dp_cmd_t   cmd,
  output htsed_pkg::dp_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output htsed_pkg::out_item_t out_data
);

  localparam int CW = $clog2(WINDOW_BYTES + 1);
  localparam int IW = $clog2(WINDOW_BYTES);

  logic [7:0]          win_r [WINDOW_BYTES];
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       skip_r;
  logic                tag_r;
  logic                nl_r;
  logic                last_r;
  logic                hold_v_r;
  logic [7:0]          hold_r;
  logic                out_v_r;
  htsed_pkg::out_item_t out_r;

  logic [htsed_pkg::SEQ_NUM-1:0] full;
  logic [htsed_pkg::SEQ_NUM-1:0] pre;
  logic [2:0]                    sel_len;
  logic [7:0]                    sel_repl;
  logic [7:0]                    head;

  logic          e_emit;
  logic [7:0]    e_byte;
  logic          e_tag;
  logic          e_nl;
  logic [CW-1:0] e_skip;

  logic                 push;
  htsed_pkg::out_item_t push_item;

  assign head = win_r[0];

  // Compare the window head against every entity, masked to the valid bytes.
  always_comb begin
    full     = '1;
    pre      = '1;
    sel_len  = '0;
    sel_repl = '0;
    for (int k = 0; k < htsed_pkg::SEQ_NUM; k++) begin
      for (int j = 0; j < htsed_pkg::SEQ_MAX; j++) begin
        if (j < int'(htsed_pkg::seq_len(3'(k)))) begin
          if (j < int'(cnt_r)) begin
            if (win_r[j] != htsed_pkg::seq_char(3'(k), 3'(j))) begin
              full[k] = 1'b0;
              pre[k]  = 1'b0;
            end
          end else begin
            full[k] = 1'b0;
          end
        end
      end
      if (int'(cnt_r) >= int'(htsed_pkg::seq_len(3'(k)))) begin
        pre[k] = 1'b0;
      end
    end
    for (int k = htsed_pkg::SEQ_NUM - 1; k >= 0; k--) begin
      if (full[k]) begin
        sel_len  = htsed_pkg::seq_len(3'(k));
        sel_repl = htsed_pkg::seq_repl(3'(k));
      end
    end
  end

  // Effect of consuming the head byte.
  always_comb begin
    e_emit = 1'b0;
    e_byte = head;
    e_tag  = tag_r;
    e_nl   = nl_r;
    e_skip = '0;
    if (skip_r != '0) begin
      e_skip = skip_r - CW'(1);
    end else if (tag_r) begin
      e_tag = (head != htsed_pkg::CH_GT);
    end else if (head == htsed_pkg::CH_LT) begin
      e_tag = 1'b1;
      e_nl  = 1'b0;
    end else if (head == htsed_pkg::CH_AMP && |full) begin
      e_emit = (sel_repl != 8'h00);
      e_byte = sel_repl;
      e_nl   = 1'b0;
      e_skip = CW'(sel_len - 3'd1);
    end else if (head == htsed_pkg::CH_NL) begin
      e_emit = ~nl_r;
      e_nl   = 1'b1;
    end else if (head == htsed_pkg::CH_TAB) begin
      e_nl = 1'b0;
    end else begin
      e_emit = 1'b1;
      e_nl   = 1'b0;
    end
  end

  assign sts.empty      = (cnt_r == '0);
  assign sts.keep       = (cnt_r != '0) && (skip_r == '0) && !tag_r && !last_r &&
                          (head == htsed_pkg::CH_AMP) && !(|full) && (|pre);
  assign sts.step_push  = e_emit & hold_v_r;
  assign sts.flush_push = hold_v_r | last_r;
  assign sts.can_push   = ~out_v_r | ~out_stall;

  // The held byte is released only once it is known whether it is the final one.
  always_comb begin
    push      = 1'b0;
    push_item = '0;
    if (cmd.step && e_emit && hold_v_r) begin
      push                = 1'b1;
      push_item.out_byte  = hold_r;
      push_item.out_valid = 1'b1;
    end else if (cmd.flush && (hold_v_r || last_r)) begin
      push                = 1'b1;
      push_item.out_byte  = hold_v_r ? hold_r : 8'h00;
      push_item.out_valid = hold_v_r;
      push_item.out_last  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      skip_r   <= '0;
      tag_r    <= 1'b0;
      nl_r     <= 1'b0;
      last_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= push | (out_v_r & out_stall);
      if (cmd.load) begin
        cnt_r  <= cnt_r + CW'(1);
        last_r <= in_data.in_last;
      end
      if (cmd.step) begin
        cnt_r  <= cnt_r - CW'(1);
        skip_r <= e_skip;
        tag_r  <= e_tag;
        nl_r   <= e_nl;
        if (e_emit) begin
          hold_v_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        hold_v_r <= 1'b0;
        if (last_r) begin
          cnt_r  <= '0;
          skip_r <= '0;
          tag_r  <= 1'b0;
          nl_r   <= 1'b0;
          last_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r[cnt_r[IW-1:0]] <= in_data.in_byte;
    end
    if (cmd.step) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      if (e_emit) begin
        hold_r <= e_byte;
      end
    end
    if (push) begin
      out_r <= push_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[rtl/html_tag_strip_entity_decode.sv]
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Strips HTML tags, decodes &lt; &gt; &amp;, drops &#39;s and &nbsp;,
// squeezes newline runs and drops tabs on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one raw byte per request, with in_last
//   on the final byte of a text. out_valid/out_stall/out_data carry cleaned
//   bytes; out_last marks the final result of a text, and a text that
//   yields nothing ends with one result whose out_valid member is 0.
//   Bytes that may still grow into an entity are held in the window and
//   rescanned with the next request.
// Timing:
//   One request at a time. A request is loaded, then the scan consumes the
//   window bytes (held bytes plus the new one, at most 6) one per cycle
//   unless a push waits on the output, sees the end of the scan and
//   flushes. A result byte is released one emitted byte late, so the
//   final one can carry out_last.
// Reset and stalls:
//   Reset empties the window and clears the tag and newline state; in_stall
//   is high during reset. While out_stall holds the output register full,
//   the scan waits at the next byte that must emit.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode #(
  parameter int WINDOW_BYTES = htsed_pkg::WINDOW_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  htsed_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output htsed_pkg::out_item_t out_data
);

  htsed_pkg::dp_cmd_t cmd;
  htsed_pkg::dp_sts_t sts;

  htsed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  htsed_dp #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.flush}))
    else $error("more than one datapath command");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_ready_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !in_stall)
    else $error("not ready after flush");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_valid) |-> out_data.out_last)
    else $error("bare end marker without last");

endmodule

[verif/tb_html_tag_strip_entity_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_tag_strip_entity_decode
// Self-checking bench for the tag strip / entity decode block. Raw text goes
// in one byte per request. A behavioral decoder in the bench predicts the
// cleaned bytes, which are checked in order against the result channel under
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_html_tag_strip_entity_decode;

  localparam int WIN_BYTES      = htsed_pkg::WINDOW_BYTES_DEF;
  localparam int HELD_MAX       = WIN_BYTES - 1;
  localparam int MAX_RESULTS    = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {ENT_LT, ENT_GT, ENT_AMP, ENT_APOS_S, ENT_NBSP, ENT_COUNT} ent_e;
  typedef enum int {MATCH_NONE, MATCH_FULL, MATCH_PREFIX} match_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  htsed_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  htsed_pkg::out_item_t out_data;

  html_tag_strip_entity_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor state
  logic [7:0] held_bytes [0:HELD_MAX-1];
  int         held_cnt;
  logic       in_tag;
  logic       last_nl;
  logic [7:0] scan_win [0:WIN_BYTES-1];
  logic [7:0] emit_buf [0:MAX_RESULTS-1];
  int         emit_n;

  htsed_pkg::out_item_t expected_clean [$];
  logic [7:0]           text_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int sent_items;
  int mismatches;
  int idle_cycles;
  bit hold_req;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void put_text(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void put_expected(input htsed_pkg::out_item_t item);
    expected_clean.insert(expected_clean.size(), item);
  endfunction

  function automatic string ent_text(int k);
    case (k)
      ENT_LT:     return "&lt;";
      ENT_GT:     return "&gt;";
      ENT_AMP:    return "&amp;";
      ENT_APOS_S: return "&#39;s";
      default:    return "&nbsp;";
    endcase
  endfunction

  function automatic logic [7:0] ent_repl(int k);
    case (k)
      ENT_LT:  return htsed_pkg::CH_LT;
      ENT_GT:  return htsed_pkg::CH_GT;
      ENT_AMP: return htsed_pkg::CH_AMP;
      default: return 8'h00;
    endcase
  endfunction

  // Compares the window from start against every entity.
  function automatic match_e match_at(int start, int avail, output int which);
    string  et;
    int     n;
    int     j;
    bit     same;
    match_e res;
    res   = MATCH_NONE;
    which = 0;
    for (int k = 0; k < ENT_COUNT; k++) begin
      et   = ent_text(k);
      n    = et.len();
      same = 1'b1;
      for (j = 0; j < n && j < avail; j++) begin
        if (scan_win[start + j] != et[j]) same = 1'b0;
      end
      if (same) begin
        if (avail >= n) begin
          which = k;
          return MATCH_FULL;
        end
        res = MATCH_PREFIX;
      end
    end
    return res;
  endfunction

  function automatic void emit_byte(logic [7:0] x);
    if (emit_n < MAX_RESULTS) begin
      emit_buf[emit_n] = x;
      emit_n++;
    end
  endfunction

  // Expected results of one accepted request.
  task automatic decode_step(input logic [7:0] b, input logic last);
    int                   len;
    int                   pos;
    int                   keep;
    int                   which;
    logic [7:0]           c;
    bit                   stop;
    bit                   done;
    match_e               m;
    string                et;
    htsed_pkg::out_item_t item;
    len = 0;
    for (int k = 0; k < held_cnt; k++) begin
      scan_win[len] = held_bytes[k];
      len++;
    end
    scan_win[len] = b;
    len++;
    emit_n = 0;
    pos    = 0;
    keep   = 0;
    stop   = 1'b0;
    while (pos < len && !stop) begin
      c = scan_win[pos];
      if (in_tag) begin
        if (c == htsed_pkg::CH_GT) in_tag = 1'b0;
        pos++;
      end else if (c == htsed_pkg::CH_LT) begin
        in_tag  = 1'b1;
        last_nl = 1'b0;
        pos++;
      end else begin
        done = 1'b0;
        if (c == htsed_pkg::CH_AMP) begin
          m = match_at(pos, len - pos, which);
          if (m == MATCH_FULL) begin
            if (ent_repl(which) != 8'h00) emit_byte(ent_repl(which));
            last_nl = 1'b0;
            et      = ent_text(which);
            pos += et.len();
            done = 1'b1;
          end else if (m == MATCH_PREFIX && !last) begin
            // still may grow: hold it for the next request
            keep = len - pos;
            stop = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (c == htsed_pkg::CH_NL) begin
            if (!last_nl) emit_byte(htsed_pkg::CH_NL);
            last_nl = 1'b1;
          end else if (c == htsed_pkg::CH_TAB) begin
            last_nl = 1'b0;
          end else begin
            emit_byte(c);
            last_nl = 1'b0;
          end
          pos++;
        end
      end
    end
    for (int k = 0; k < keep; k++) held_bytes[k] = scan_win[pos + k];
    held_cnt = keep;
    for (int k = 0; k < emit_n; k++) begin
      item.out_byte  = emit_buf[k];
      item.out_valid = 1'b1;
      item.out_last  = last && (k == emit_n - 1);
      put_expected(item);
    end
    if (last) begin
      held_cnt = 0;
      in_tag   = 1'b0;
      last_nl  = 1'b0;
      if (emit_n == 0) begin
        item.out_byte  = 8'h00;
        item.out_valid = 1'b0;
        item.out_last  = 1'b1;
        put_expected(item);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    do @(posedge clk); while (in_stall);
    decode_step(b, last);
    sent_items++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  // Mostly well-formed markup with random content, cut at a random length.
  task automatic build_random_text(input int target);
    string et;
    int    n;
    while (text_q.size() < target) begin
      case ($urandom_range(11))
        0, 1: add_str(ent_text($urandom_range(ENT_COUNT - 1)));
        2: begin
          et = ent_text($urandom_range(ENT_COUNT - 1));
          n  = $urandom_range(et.len() - 1, 1);
          add_str(et.substr(0, n - 1));
        end
        3: begin
          put_text(htsed_pkg::CH_LT);
          repeat ($urandom_range(3)) put_text(8'($urandom_range(122, 97)));
          put_text(htsed_pkg::CH_GT);
        end
        4: repeat ($urandom_range(3, 1)) put_text(htsed_pkg::CH_NL);
        5: put_text(htsed_pkg::CH_TAB);
        6: put_text(8'($urandom_range(255)));
        default: put_text(8'($urandom_range(126, 32)));
      endcase
    end
    while (text_q.size() > target) void'(text_q.pop_back());
  endtask

  task automatic test_entity_decode();
    add_str("&lt;&gt;");
    send_text();
    add_str("&amp;&#39;s");
    send_text();
  endtask

  task automatic test_tag_and_whitespace();
    put_text(8'h00);
    add_str("\n\n\t\n");
    put_text(8'hFF);
    add_str("&nbsp;&g");
    send_text();
    add_str("<a");
    send_text();
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct, input int items);
    int stop_at;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at       = sent_items + items;
    while (sent_items < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // noise: raw bytes of any value
        repeat ($urandom_range(8, 1)) put_text(8'($urandom_range(255)));
      end else begin
        build_random_text($urandom_range(16, 1));
      end
      send_text();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    while (text_q.size() < 40) build_random_text(text_q.size() + $urandom_range(12, 1));
    send_text();
  endtask

  // result receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    htsed_pkg::out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_clean.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte=%02h valid=%b last=%b",
                   out_data.out_byte, out_data.out_valid, out_data.out_last);
      end else begin
        exp_item = expected_clean.pop_front();
        if (out_data.out_byte !== exp_item.out_byte ||
            out_data.out_valid !== exp_item.out_valid ||
            out_data.out_last !== exp_item.out_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp byte=%02h valid=%b last=%b, got byte=%02h valid=%b last=%b",
                     exp_item.out_byte, exp_item.out_valid, exp_item.out_last,
                     out_data.out_byte, out_data.out_valid, out_data.out_last);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_items    = 0;
    mismatches    = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    held_cnt      = 0;
    in_tag        = 1'b0;
    last_nl       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_entity_decode();
    test_tag_and_whitespace();
    test_random_stream(28, 77, 115);
    test_random_stream(77, 28, 115);
    test_random_stream(0, 0, 115);
    test_backpressure();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_clean.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
